[design/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  // Commands carried by an input item.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOFIT   = 2'd1;
  localparam logic [1:0] STATUS_BADADDR = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  // One entry of the block table.
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        free;
  } ffba_entry_t;

  // Table read address select.
  typedef enum logic [1:0] {
    RD_I    = 2'd0,
    RD_NEXT = 2'd1,
    RD_JM1  = 2'd2,
    RD_JP1  = 2'd3
  } ffba_rd_sel_e;

  // Table write address and data select.
  typedef enum logic [1:0] {
    WR_CUR  = 2'd0,
    WR_J    = 2'd1,
    WR_INS  = 2'd2,
    WR_INIT = 2'd3
  } ffba_wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         in_ready;
    logic         rd_en;
    ffba_rd_sel_e rd_sel;
    logic         wr_en;
    ffba_wr_sel_e wr_sel;
    logic         alloc_take;
    logic         free_take;
    logic         merge;
    logic         inc_i;
    logic         j_dec;
    logic         j_inc;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         init;
    logic         set_status;
    logic [1:0]   status;
    logic         out_load;
  } ffba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_take;
    logic cmd_free;
    logic addr_zero;
    logic i_lt_cnt;
    logic fit;
    logic match;
    logic next_ok;
    logic rd_free;
    logic split_q;
    logic j_gt_i1;
    logic j1_lt_cnt;
    logic out_busy;
    logic init_pend;
  } ffba_stat_t;

endpackage

`default_nettype wire

[design/ffba_if.sv]
// ----------------------------------------------------------------------------
// ffba_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one item is one allocate or free command.
interface ffba_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] request_size;
  logic [31:0] free_address;

  modport source (output valid, command, request_size, free_address, input ready);
  modport sink (input valid, command, request_size, free_address, output ready);
endinterface

// Result channel: one item per request.
interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] address;

  modport source (output valid, status, address, input ready);
  modport sink (input valid, status, address, output ready);
endinterface

`default_nettype wire

[design/ffba_datapath.sv]
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table memory, walk and shift indexes, arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_datapath
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  ffba_req_if.sink        req_i,
  ffba_rsp_if.source      rsp_o,
  input  wire ffba_cmd_t  cmd_i,
  output ffba_stat_t      stat_o
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);
  localparam logic [31:0] Hdr32 = 32'(HEADER_BYTES);
  localparam logic [32:0] Hdr33 = 33'(HEADER_BYTES);
  localparam logic [33:0] Hdr34 = 34'(HEADER_BYTES);

  // Block table, one write and one registered read per cycle.
  ffba_entry_t tbl_mem [MAX_BLOCKS];

  logic [31:0]   base_q, limit_q;
  logic          init_pend_q;
  logic [CW-1:0] count_q, i_q, j_q;
  logic          cmd_q;
  logic [31:0]   req_q, faddr_q;
  ffba_entry_t   rd_q, cur_q, ins_q;
  logic          split_q;
  logic [31:0]   res_addr_q;
  logic [1:0]    res_status_q;
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [31:0]   out_addr_q;

  logic          in_take;
  logic [32:0]   cut;
  logic          fit, split, match;
  logic [31:0]   payload;
  logic [33:0]   msum;
  logic [31:0]   msize;
  logic [32:0]   need;
  logic [31:0]   init_size;
  logic [CW:0]   i_p1, j_p1;
  logic [IW-1:0] rd_addr, wr_addr;
  ffba_entry_t   wr_data;

  assign in_take = req_i.valid && cmd_i.in_ready;
  assign req_i.ready = cmd_i.in_ready;

  // Fit, split and address match on the entry just read.
  assign cut     = {1'b0, req_q} + Hdr33;
  assign fit     = rd_q.free && (rd_q.size >= req_q);
  assign split   = ({1'b0, rd_q.size} > cut) && (count_q < MaxCnt);
  assign payload = base_q + rd_q.offset + Hdr32;
  assign match   = (payload == faddr_q);

  // Merged size saturates at the top of the address range.
  assign msum  = {2'b0, cur_q.size} + {2'b0, rd_q.size} + Hdr34;
  assign msize = (msum[33:32] != 2'b00) ? 32'hFFFF_FFFF : msum[31:0];

  // Size of the single block that the table starts with.
  assign need      = {1'b0, base_q} + Hdr33;
  assign init_size = ({1'b0, limit_q} >= need) ? 32'({1'b0, limit_q} - need) : 32'd0;

  assign i_p1 = {1'b0, i_q} + 1'b1;
  assign j_p1 = {1'b0, j_q} + 1'b1;

  always_comb begin
    stat_o.in_take   = in_take;
    stat_o.cmd_free  = (cmd_q == CMD_FREE);
    stat_o.addr_zero = (faddr_q == 32'd0);
    stat_o.i_lt_cnt  = (i_q < count_q);
    stat_o.fit       = fit;
    stat_o.match     = match;
    stat_o.next_ok   = (i_p1 < {1'b0, count_q});
    stat_o.rd_free   = rd_q.free;
    stat_o.split_q   = split_q;
    stat_o.j_gt_i1   = ({1'b0, j_q} > i_p1);
    stat_o.j1_lt_cnt = (j_p1 < {1'b0, count_q});
    stat_o.out_busy  = out_valid_q && !rsp_o.ready;
    stat_o.init_pend = init_pend_q;
  end

  // Table address and data selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_I:    rd_addr = i_q[IW-1:0];
      RD_NEXT: rd_addr = i_p1[IW-1:0];
      RD_JM1:  rd_addr = IW'(j_q - 1'b1);
      RD_JP1:  rd_addr = j_p1[IW-1:0];
      default: rd_addr = i_q[IW-1:0];
    endcase
    case (cmd_i.wr_sel)
      WR_CUR: begin
        wr_addr = i_q[IW-1:0];
        wr_data = cur_q;
      end
      WR_J: begin
        wr_addr = j_q[IW-1:0];
        wr_data = rd_q;
      end
      WR_INS: begin
        wr_addr = i_p1[IW-1:0];
        wr_data = ins_q;
      end
      WR_INIT: begin
        wr_addr = '0;
        wr_data = '{offset: 32'd0, size: init_size, free: 1'b1};
      end
      default: begin
        wr_addr = i_q[IW-1:0];
        wr_data = cur_q;
      end
    endcase
  end

  // Table memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= tbl_mem[rd_addr];
    end
  end

  // Configuration, table count and pending initialization.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 32'd0;
      limit_q     <= 32'd65536;
      init_pend_q <= 1'b1;
      count_q     <= CW'(1);
    end else begin
      if (cmd_i.init) begin
        init_pend_q <= 1'b0;
        count_q     <= CW'(1);
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (cfg_we_i) begin
        init_pend_q <= 1'b1;
        if (cfg_index_i == CFG_BASE) begin
          base_q <= cfg_data_i;
        end else begin
          limit_q <= cfg_data_i;
        end
      end
    end
  end

  // Request capture, walk and shift indexes, working entries.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= req_i.command;
      req_q   <= req_i.request_size;
      faddr_q <= req_i.free_address;
      i_q     <= '0;
    end else if (cmd_i.inc_i) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.alloc_take) begin
      cur_q      <= '{offset: rd_q.offset, size: (split ? req_q : rd_q.size), free: 1'b0};
      ins_q      <= '{offset: rd_q.offset + cut[31:0], size: rd_q.size - cut[31:0],
                      free: 1'b1};
      split_q    <= split;
      res_addr_q <= payload;
      j_q        <= count_q;
    end else if (cmd_i.free_take) begin
      cur_q   <= '{offset: rd_q.offset, size: rd_q.size, free: 1'b1};
      split_q <= 1'b0;
    end else if (cmd_i.merge) begin
      cur_q.size <= msize;
      j_q        <= i_p1[CW-1:0];
    end else if (cmd_i.j_dec) begin
      j_q <= j_q - 1'b1;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= (res_status_q == STATUS_OK && cmd_q == CMD_ALLOC) ? res_addr_q : 32'd0;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.address = out_addr_q;

endmodule

`default_nettype wire

[design/ffba_ctrl.sv]
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for table walk, split insert, merge delete and initialization.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl
  import ffba_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ffba_stat_t stat_i,
  output ffba_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_WALK    = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_NCHECK  = 4'd3;
  localparam logic [3:0] S_WCUR    = 4'd4;
  localparam logic [3:0] S_MERGE_W = 4'd5;
  localparam logic [3:0] S_SH_TEST = 4'd6;
  localparam logic [3:0] S_SH_W    = 4'd7;
  localparam logic [3:0] S_DL_TEST = 4'd8;
  localparam logic [3:0] S_DL_W    = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (stat_i.init_pend) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_INIT;
          cmd_o.init   = 1'b1;
        end else begin
          cmd_o.in_ready = 1'b1;
          if (stat_i.in_take) begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat_i.cmd_free && stat_i.addr_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STATUS_BADADDR;
          state_d          = S_FIN;
        end else if (!stat_i.i_lt_cnt) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = stat_i.cmd_free ? STATUS_BADADDR : STATUS_NOFIT;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_I;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat_i.cmd_free && stat_i.fit) begin
          cmd_o.alloc_take = 1'b1;
          state_d          = S_WCUR;
        end else if (stat_i.cmd_free && stat_i.match) begin
          cmd_o.free_take = 1'b1;
          if (stat_i.next_ok) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_NEXT;
            state_d      = S_NCHECK;
          end else begin
            state_d = S_WCUR;
          end
        end else begin
          cmd_o.inc_i = 1'b1;
          state_d     = S_WALK;
        end
      end
      S_NCHECK: begin
        if (stat_i.rd_free) begin
          cmd_o.merge = 1'b1;
          state_d     = S_MERGE_W;
        end else begin
          state_d = S_WCUR;
        end
      end
      S_WCUR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_CUR;
        if (stat_i.split_q) begin
          state_d = S_SH_TEST;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STATUS_OK;
          state_d          = S_FIN;
        end
      end
      S_MERGE_W: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_CUR;
        state_d      = S_DL_TEST;
      end
      // Open a slot after the split block, moving the tail up one entry.
      S_SH_TEST: begin
        if (stat_i.j_gt_i1) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_JM1;
          state_d      = S_SH_W;
        end else begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel     = WR_INS;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STATUS_OK;
          state_d          = S_FIN;
        end
      end
      S_SH_W: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_J;
        cmd_o.j_dec  = 1'b1;
        state_d      = S_SH_TEST;
      end
      // Close the gap left by the merged block, moving the tail down.
      S_DL_TEST: begin
        if (stat_i.j1_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_JP1;
          state_d      = S_DL_W;
        end else begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STATUS_OK;
          state_d          = S_FIN;
        end
      end
      S_DL_W: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_J;
        cmd_o.j_inc  = 1'b1;
        state_d      = S_DL_TEST;
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over an address-ordered block table.
// ----------------------------------------------------------------------------
// Each request item walks the table, one entry at a time in the states
// S_WALK and S_CHECK, during the first-fit or address search, and then
// moves table entries in S_SH_TEST/S_SH_W or S_DL_TEST/S_DL_W when a
// split inserts an entry or a merge removes one. The walk and the move
// together never cover more than the N valid entries, and a finished
// result may wait in S_FIN for the previous result to leave. After reset
// and after each configuration write the block rebuilds the table as a
// single free block before it takes the next item. A finished result waits
// in an output register, and the next item is accepted as soon as the
// sequencer is idle.
`default_nettype none

module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  ffba_req_if.sink         req_i,
  ffba_rsp_if.source       rsp_o
);

  ffba_cmd_t  cmd;
  ffba_stat_t stat;

  ffba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  ffba_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire
